/* hw/rtl/i2cee_pkg.sv */
// Package for the I2C EEPROM random read master.
// Holds register defaults, register indexes and status codes; no dependencies.
package i2cee_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_CODE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ADDRESS  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT  = 2'd3;

  localparam logic        ADDRESS_MODE_RST = 1'b0;
  localparam logic [7:0]  DEVICE_CODE_RST  = 8'hA0;
  localparam logic [15:0] MAX_ADDRESS_RST  = 16'hFFFF;
  localparam logic [2:0]  RETRY_LIMIT_RST  = 3'd3;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_REJECTED     = 2'd1;
  localparam logic [1:0] STATUS_NO_ACK_WRITE = 2'd2;
  localparam logic [1:0] STATUS_NO_ACK_READ  = 2'd3;

endpackage

/* hw/rtl/i2c_eeprom_random_read_master.sv */
// Result registered the next cycle; one word per cycle unless a result stalls.
// Each input word is one bus timing slot, handled by a single pass of next-state
// logic between the stored sequencer state and the result register.
// A waiting result does not block intake while out_ready is high in the same cycle.
// Reset (rst, synchronous) returns the sequencer to idle, pins to scl 0, sda 1,
// output enable 1, write enable 0, and registers to their default values.
// Depends on i2cee_pkg.
module i2c_eeprom_random_read_master #(
  parameter int unsigned MAX_LENGTH = i2cee_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [i2cee_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic [15:0]                        read_address,
  input  logic [7:0]                         read_length,
  input  logic                               sda_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               scl_level,
  output logic                               sda_level,
  output logic                               sda_output_enable,
  output logic                               write_enable,
  output logic                               byte_valid,
  output logic [7:0]                         read_byte,
  output logic                               last_byte,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [1:0]                         status
);

  typedef enum logic [4:0] {
    P_IDLE, P_WE, P_W_START, P_W_DEV, P_W_ACK, P_ADDR_HI, P_ADDR_HI_ACK,
    P_ADDR_LO, P_ADDR_LO_ACK, P_R_START, P_R_DEV, P_R_ACK, P_READ,
    P_SEND_ACK, P_NOACK, P_STOP, P_FAIL_STOP
  } phase_t;

  typedef enum logic [2:0] {
    K_WE, K_START, K_STOP, K_WRITE, K_ACKCHK, K_READ, K_SENDACK, K_NOACK
  } kind_t;

  // Configuration registers.
  logic        address_mode;
  logic [7:0]  device_code;
  logic [15:0] max_address;
  logic [2:0]  retry_limit;

  // Sequencer state; slot is the position within the current operation.
  phase_t      phase, phase_next;
  logic [4:0]  slot, slot_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [4:0]  byte_count, byte_count_next;
  logic [2:0]  retry_count, retry_count_next;
  logic        ack_missing, ack_missing_next;
  logic [15:0] held_address, held_address_next;
  logic [4:0]  held_length, held_length_next;
  logic        pin_scl, pin_scl_next;
  logic        pin_sda, pin_sda_next;
  logic        pin_oe, pin_oe_next;
  logic        pin_we, pin_we_next;

  logic        valid_next, last_next, done_next;
  logic [7:0]  rbyte_next;
  logic [1:0]  status_next;

  kind_t       kind;
  logic [4:0]  kind_len;
  logic        accept;
  logic [2:0]  retry_inc;
  logic [2:0]  eff_limit;
  logic [7:0]  dev_byte;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (phase)
      P_WE:                                   kind = K_WE;
      P_W_START, P_R_START:                   kind = K_START;
      P_STOP, P_FAIL_STOP:                    kind = K_STOP;
      P_W_DEV, P_ADDR_HI, P_ADDR_LO, P_R_DEV: kind = K_WRITE;
      P_READ:                                 kind = K_READ;
      P_SEND_ACK:                             kind = K_SENDACK;
      P_NOACK:                                kind = K_NOACK;
      default:                                kind = K_ACKCHK;
    endcase
    case (kind)
      K_WE:    kind_len = 5'd1;
      K_WRITE: kind_len = 5'd17;
      K_READ:  kind_len = 5'd20;
      K_NOACK: kind_len = 5'd6;
      default: kind_len = 5'd8;
    endcase
  end

  assign retry_inc = (retry_count < 3'd7) ? retry_count + 3'd1 : retry_count;
  assign eff_limit = (retry_limit == 3'd0) ? 3'd1 : retry_limit;
  // In single-byte mode address bits 10..8 ride in device byte bits 3..1.
  assign dev_byte  = address_mode ? (device_code | {4'd0, held_address[10:8], 1'b0})
                                  : device_code;

  always_comb begin
    phase_next          = phase;
    slot_next           = slot;
    shift_register_next = shift_register;
    byte_count_next     = byte_count;
    retry_count_next    = retry_count;
    ack_missing_next    = ack_missing;
    held_address_next   = held_address;
    held_length_next    = held_length;
    pin_scl_next        = pin_scl;
    pin_sda_next        = pin_sda;
    pin_oe_next         = pin_oe;
    pin_we_next         = pin_we;
    valid_next          = 1'b0;
    rbyte_next          = 8'd0;
    last_next           = 1'b0;
    done_next           = 1'b0;
    status_next         = i2cee_pkg::STATUS_OK;

    if (func) begin
      if (phase == P_IDLE) begin
        if (read_address > max_address || read_length > 8'(MAX_LENGTH)) begin
          done_next   = 1'b1;
          status_next = i2cee_pkg::STATUS_REJECTED;
        end else begin
          held_address_next   = read_address;
          held_length_next    = read_length[4:0];
          ack_missing_next    = 1'b1;
          retry_count_next    = 3'd0;
          byte_count_next     = 5'd0;
          phase_next          = P_WE;
          slot_next           = 5'd0;
          shift_register_next = 8'd0;
        end
      end
    end else if (phase != P_IDLE) begin
      case (kind)
        K_WE: pin_we_next = 1'b1;
        K_START: begin
          case (slot)
            5'd0:    pin_sda_next = 1'b1;
            5'd2:    pin_scl_next = 1'b1;
            5'd4:    pin_sda_next = 1'b0;
            5'd6:    pin_scl_next = 1'b0;
            default: ;
          endcase
        end
        K_STOP: begin
          case (slot)
            5'd0:    pin_sda_next = 1'b0;
            5'd2:    pin_scl_next = 1'b1;
            5'd4:    pin_sda_next = 1'b1;
            5'd6:    pin_scl_next = 1'b0;
            default: ;
          endcase
        end
        K_WRITE: begin
          if (!slot[0]) begin
            pin_scl_next = 1'b0;
            if (slot < 5'd16) begin
              pin_sda_next        = shift_register[7];
              shift_register_next = {shift_register[6:0], 1'b0};
            end
          end else begin
            pin_scl_next = 1'b1;
          end
        end
        K_ACKCHK: begin
          case (slot)
            5'd0: pin_sda_next = 1'b1;
            5'd2: begin
              pin_oe_next  = 1'b0;
              pin_scl_next = 1'b1;
            end
            5'd3:    ack_missing_next = sda_in;
            5'd4:    pin_scl_next = 1'b0;
            5'd6:    pin_oe_next = 1'b1;
            default: ;
          endcase
        end
        K_READ: begin
          if (slot == 5'd0) begin
            pin_oe_next = 1'b0;
          end else if (slot >= 5'd2 && slot < 5'd18) begin
            if (!slot[0]) begin
              pin_scl_next        = 1'b1;
              shift_register_next = {shift_register[6:0], sda_in};
            end else begin
              pin_scl_next = 1'b0;
            end
          end else if (slot == 5'd18) begin
            pin_oe_next = 1'b1;
          end
        end
        K_SENDACK: begin
          case (slot)
            5'd0:    pin_sda_next = 1'b0;
            5'd2:    pin_scl_next = 1'b1;
            5'd4:    pin_scl_next = 1'b0;
            5'd6:    pin_sda_next = 1'b1;
            default: ;
          endcase
        end
        default: begin
          case (slot)
            5'd0:    pin_sda_next = 1'b1;
            5'd2:    pin_scl_next = 1'b1;
            5'd4:    pin_scl_next = 1'b0;
            default: ;
          endcase
        end
      endcase

      if (slot + 5'd1 < kind_len) begin
        slot_next = slot + 5'd1;
      end else begin
        // Every transition restarts the slot count and reloads the shifter.
        slot_next           = 5'd0;
        shift_register_next = 8'd0;
        case (phase)
          P_WE: begin
            retry_count_next = 3'd0;
            phase_next       = P_W_START;
          end
          P_W_START: begin
            phase_next          = P_W_DEV;
            shift_register_next = {dev_byte[7:1], 1'b0};
          end
          P_W_DEV: phase_next = P_W_ACK;
          P_W_ACK: begin
            retry_count_next = retry_inc;
            if (!ack_missing) begin
              if (address_mode) begin
                phase_next          = P_ADDR_LO;
                shift_register_next = held_address[7:0];
              end else begin
                phase_next          = P_ADDR_HI;
                shift_register_next = held_address[15:8];
              end
            end else if (retry_inc < eff_limit) begin
              phase_next = P_W_START;
            end else begin
              phase_next = P_FAIL_STOP;
            end
          end
          P_ADDR_HI: phase_next = P_ADDR_HI_ACK;
          P_ADDR_HI_ACK: begin
            phase_next          = P_ADDR_LO;
            shift_register_next = held_address[7:0];
          end
          P_ADDR_LO: phase_next = P_ADDR_LO_ACK;
          P_ADDR_LO_ACK: begin
            ack_missing_next = 1'b1;
            retry_count_next = 3'd0;
            phase_next       = P_R_START;
          end
          P_R_START: begin
            phase_next          = P_R_DEV;
            shift_register_next = {dev_byte[7:1], 1'b1};
          end
          P_R_DEV: phase_next = P_R_ACK;
          P_R_ACK: begin
            retry_count_next = retry_inc;
            if (!ack_missing) begin
              byte_count_next = 5'd0;
              phase_next      = (held_length != 5'd0) ? P_READ : P_NOACK;
            end else if (retry_inc < eff_limit) begin
              phase_next = P_R_START;
            end else begin
              phase_next = P_NOACK;
            end
          end
          P_READ: begin
            valid_next      = 1'b1;
            rbyte_next      = shift_register;
            byte_count_next = byte_count + 5'd1;
            if (byte_count + 5'd1 < held_length) begin
              phase_next = P_SEND_ACK;
            end else begin
              last_next  = 1'b1;
              phase_next = P_NOACK;
            end
          end
          P_SEND_ACK: phase_next = P_READ;
          P_NOACK:    phase_next = P_STOP;
          P_STOP: begin
            pin_we_next = 1'b0;
            done_next   = 1'b1;
            status_next = ack_missing ? i2cee_pkg::STATUS_NO_ACK_READ
                                      : i2cee_pkg::STATUS_OK;
            phase_next  = P_IDLE;
          end
          default: begin
            pin_we_next = 1'b0;
            done_next   = 1'b1;
            status_next = i2cee_pkg::STATUS_NO_ACK_WRITE;
            phase_next  = P_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_mode   <= i2cee_pkg::ADDRESS_MODE_RST;
      device_code    <= i2cee_pkg::DEVICE_CODE_RST;
      max_address    <= i2cee_pkg::MAX_ADDRESS_RST;
      retry_limit    <= i2cee_pkg::RETRY_LIMIT_RST;
      phase          <= P_IDLE;
      slot           <= 5'd0;
      shift_register <= 8'd0;
      byte_count     <= 5'd0;
      retry_count    <= 3'd0;
      ack_missing    <= 1'b1;
      held_address   <= 16'd0;
      held_length    <= 5'd0;
      pin_scl        <= 1'b0;
      pin_sda        <= 1'b1;
      pin_oe         <= 1'b1;
      pin_we         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2cee_pkg::REG_ADDRESS_MODE: address_mode <= cfg_data[0];
          i2cee_pkg::REG_DEVICE_CODE:  device_code  <= cfg_data[7:0];
          i2cee_pkg::REG_MAX_ADDRESS:  max_address  <= cfg_data[15:0];
          i2cee_pkg::REG_RETRY_LIMIT:  retry_limit  <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase          <= phase_next;
        slot           <= slot_next;
        shift_register <= shift_register_next;
        byte_count     <= byte_count_next;
        retry_count    <= retry_count_next;
        ack_missing    <= ack_missing_next;
        held_address   <= held_address_next;
        held_length    <= held_length_next;
        pin_scl        <= pin_scl_next;
        pin_sda        <= pin_sda_next;
        pin_oe         <= pin_oe_next;
        pin_we         <= pin_we_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word register; it loads only when a new word is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level         <= pin_scl_next;
      sda_level         <= pin_sda_next;
      sda_output_enable <= pin_oe_next;
      write_enable      <= pin_we_next;
      byte_valid        <= valid_next;
      read_byte         <= rbyte_next;
      last_byte         <= last_next;
      busy_res          <= (phase_next != P_IDLE);
      done_res          <= done_next;
      status            <= status_next;
    end
  end

endmodule

/* hw/rtl/i2cee_checker.sv */
// Port-level checker for the I2C EEPROM random read master, with its bind.
// Depends on i2cee_pkg and the top level's ports.
module i2cee_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               write_enable,
  input logic                               byte_valid,
  input logic [7:0]                         read_byte,
  input logic                               last_byte,
  input logic                               busy_res,
  input logic                               done_res,
  input logic [1:0]                         status
);

  // A result word that is not taken stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == i2cee_pkg::STATUS_OK)
    else $error("status reported without completion");

  // A finished transaction leaves the master not busy and write enable low.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !write_enable)
    else $error("completion while still busy or write enabled");

  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> byte_valid && busy_res)
    else $error("last byte marker without a byte");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> read_byte == 8'd0)
    else $error("read byte nonzero without a byte");

endmodule

bind i2c_eeprom_random_read_master i2cee_checker u_i2cee_checker (.*);
